// ----- hw/rtl/bcomp_pkg.sv -----
// Shared types and constants for the barometer compensation pipeline.
// No dependencies; used by barometer_compensation.sv.
package bcomp_pkg;

  localparam int RAW_W      = 24;
  localparam int CAL_W      = 16;
  localparam int CAL_WORDS  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_STAGES = 9;
  localparam int OUT_W      = 32;

  // Temperature thresholds in 0.01 C, at the width of the first-order temperature
  localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [18:0] TEMP_COLD = -19'sd1500;

  // Calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENS  = 3'd0,
    REG_PRESSURE_OFF   = 3'd1,
    REG_SENS_TCO       = 3'd2,
    REG_OFF_TCO        = 3'd3,
    REG_REF_TEMP       = 3'd4,
    REG_TEMP_TCO       = 3'd5
  } cal_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pressure_out;
    logic signed [OUT_W-1:0] temperature_out;
  } out_t;

endpackage

// ----- hw/rtl/barometer_compensation.sv -----
// Barometer compensation pipeline: raw pressure/temperature to calibrated values.
// Depends on bcomp_pkg for payload types, register indexes and constants.
//
// Turns one raw pressure/temperature reading pair into compensated pressure
// (0.01 mbar) and temperature (0.01 C), both as the low 32 bits of the exact
// signed result, including the second-order corrections below 20.00 C and the
// extra term below -15.00 C. The six 16-bit calibration words are written on
// the cfg_ port (index 0..5, others are dropped) and must only change while
// the pipeline is empty. Throughput is one transfer per cycle unless out_ready
// stalls the output; each item passes through the nine register stages:
// temperature difference, the four difference products, first-order terms,
// the two squares, the correction terms, final offset/sensitivity, the two
// partial products of the 24 x 40 bit pressure multiply, their sum, and the
// final shift and subtract in the output register. Each stage holds its item
// while the next one is full and stalled, so bubbles collapse and in_ready
// drops only when all nine stages are occupied.
module barometer_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bcomp_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bcomp_pkg::out_t                   out_data,
  input  logic                              cfg_we,
  input  logic [bcomp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcomp_pkg::CAL_W-1:0]       cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Calibration words
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::CAL_W-1:0] cal_r [bcomp_pkg::CAL_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bcomp_pkg::CAL_WORDS; i++) begin
        cal_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcomp_pkg::REG_PRESSURE_SENS: cal_r[bcomp_pkg::REG_PRESSURE_SENS] <= cfg_wdata;
        bcomp_pkg::REG_PRESSURE_OFF:  cal_r[bcomp_pkg::REG_PRESSURE_OFF]  <= cfg_wdata;
        bcomp_pkg::REG_SENS_TCO:      cal_r[bcomp_pkg::REG_SENS_TCO]      <= cfg_wdata;
        bcomp_pkg::REG_OFF_TCO:       cal_r[bcomp_pkg::REG_OFF_TCO]       <= cfg_wdata;
        bcomp_pkg::REG_REF_TEMP:      cal_r[bcomp_pkg::REG_REF_TEMP]      <= cfg_wdata;
        bcomp_pkg::REG_TEMP_TCO:      cal_r[bcomp_pkg::REG_TEMP_TCO]      <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids and backpressure. A stage advances when it is empty or
  // when the stage after it advances; the last stage is the output register.
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::NUM_STAGES-1:0] v_r;
  logic [bcomp_pkg::NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[bcomp_pkg::NUM_STAGES-1] = !v_r[bcomp_pkg::NUM_STAGES-1] || out_ready;
    for (int k = bcomp_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < bcomp_pkg::NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[bcomp_pkg::NUM_STAGES-1];

  // ---------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5 * 2^8
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::RAW_W-1:0] s1_d1_r;
  logic signed [24:0]          s1_dt_r;
  logic signed [24:0]          s1_dt_nxt;

  assign s1_dt_nxt = $signed({1'b0, in_data.raw_temperature})
                   - $signed({1'b0, cal_r[bcomp_pkg::REG_REF_TEMP], 8'h00});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_d1_r <= in_data.raw_pressure;
      s1_dt_r <= s1_dt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the four products of dT (C6, C4, C3 and dT itself)
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::RAW_W-1:0] s2_d1_r;
  logic signed [41:0]          s2_p6_r, s2_p4_r, s2_p3_r;
  logic signed [41:0]          s2_p6_nxt, s2_p4_nxt, s2_p3_nxt;
  logic signed [49:0]          s2_pdd_r, s2_pdd_nxt;

  always_comb begin
    s2_p6_nxt  = s1_dt_r * $signed({1'b0, cal_r[bcomp_pkg::REG_TEMP_TCO]});
    s2_p4_nxt  = s1_dt_r * $signed({1'b0, cal_r[bcomp_pkg::REG_OFF_TCO]});
    s2_p3_nxt  = s1_dt_r * $signed({1'b0, cal_r[bcomp_pkg::REG_SENS_TCO]});
    s2_pdd_nxt = s1_dt_r * s1_dt_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_d1_r  <= s1_d1_r;
      s2_p6_r  <= s2_p6_nxt;
      s2_p4_r  <= s2_p4_nxt;
      s2_p3_r  <= s2_p3_nxt;
      s2_pdd_r <= s2_pdd_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: first-order TEMP, OFF, SENS and the T2 term
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::RAW_W-1:0] s3_d1_r;
  logic signed [18:0]          s3_temp1_r, s3_temp1_nxt;
  logic signed [35:0]          s3_off1_r, s3_off1_nxt;
  logic signed [35:0]          s3_sens1_r, s3_sens1_nxt;
  logic [16:0]                 s3_t2_r;
  logic signed [35:0]          off_sh, off_base, sens_sh, sens_base;

  always_comb begin
    off_sh       = $signed(s2_p4_r[41:7]);
    off_base     = $signed({4'b0, cal_r[bcomp_pkg::REG_PRESSURE_OFF], 16'h0000});
    sens_sh      = $signed(s2_p3_r[41:8]);
    sens_base    = $signed({5'b0, cal_r[bcomp_pkg::REG_PRESSURE_SENS], 15'h0000});
    s3_temp1_nxt = $signed(s2_p6_r[41:23]) + bcomp_pkg::TEMP_REF;
    s3_off1_nxt  = off_base + off_sh;
    s3_sens1_nxt = sens_base + sens_sh;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_d1_r    <= s2_d1_r;
      s3_temp1_r <= s3_temp1_nxt;
      s3_off1_r  <= s3_off1_nxt;
      s3_sens1_r <= s3_sens1_nxt;
      s3_t2_r    <= s2_pdd_r[47:31];  // dT^2 is never negative
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squares of (TEMP - 20.00 C) and (TEMP + 15.00 C), threshold flags
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::RAW_W-1:0] s4_d1_r;
  logic signed [18:0]          s4_temp1_r;
  logic signed [35:0]          s4_off1_r, s4_sens1_r;
  logic [16:0]                 s4_t2_r;
  logic [35:0]                 s4_lo2_r, s4_vlo2_r;
  logic                        s4_below_ref_r, s4_below_cold_r;
  logic signed [18:0]          lo;
  logic signed [19:0]          vlo;
  logic signed [37:0]          lo_sq;
  logic signed [39:0]          vlo_sq;

  always_comb begin
    lo     = s3_temp1_r - bcomp_pkg::TEMP_REF;
    vlo    = s3_temp1_r - bcomp_pkg::TEMP_COLD;
    lo_sq  = lo * lo;
    vlo_sq = vlo * vlo;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_d1_r         <= s3_d1_r;
      s4_temp1_r      <= s3_temp1_r;
      s4_off1_r       <= s3_off1_r;
      s4_sens1_r      <= s3_sens1_r;
      s4_t2_r         <= s3_t2_r;
      s4_lo2_r        <= lo_sq[35:0];
      s4_vlo2_r       <= vlo_sq[35:0];  // only used when cold, where it fits
      s4_below_ref_r  <= s3_temp1_r < bcomp_pkg::TEMP_REF;
      s4_below_cold_r <= s3_temp1_r < bcomp_pkg::TEMP_COLD;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: OFF2, SENS2 and the corrected temperature
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::RAW_W-1:0] s5_d1_r;
  logic signed [35:0]          s5_off1_r, s5_sens1_r;
  logic signed [19:0]          s5_temp_r, s5_temp_nxt;
  logic [38:0]                 s5_off2_r, s5_off2_nxt;
  logic [38:0]                 s5_sens2_r, s5_sens2_nxt;
  logic [38:0]                 lo5, vlo7;
  logic [39:0]                 vlo11;
  logic signed [19:0]          temp1_ext, t2_ext;

  always_comb begin
    lo5       = {1'b0, s4_lo2_r, 2'b00} + {3'b000, s4_lo2_r};
    vlo7      = {s4_vlo2_r, 3'b000} - {3'b000, s4_vlo2_r};
    vlo11     = {1'b0, s4_vlo2_r, 3'b000} + {3'b000, s4_vlo2_r, 1'b0}
              + {4'b0000, s4_vlo2_r};
    temp1_ext = s4_temp1_r;
    t2_ext    = $signed({3'b000, s4_t2_r});
    if (s4_below_ref_r) begin
      s5_off2_nxt  = {1'b0, lo5[38:1]} + (s4_below_cold_r ? vlo7 : '0);
      s5_sens2_nxt = {2'b00, lo5[38:2]} + (s4_below_cold_r ? vlo11[39:1] : '0);
      s5_temp_nxt  = temp1_ext - t2_ext;
    end else begin
      s5_off2_nxt  = '0;
      s5_sens2_nxt = '0;
      s5_temp_nxt  = temp1_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_d1_r    <= s4_d1_r;
      s5_off1_r  <= s4_off1_r;
      s5_sens1_r <= s4_sens1_r;
      s5_temp_r  <= s5_temp_nxt;
      s5_off2_r  <= s5_off2_nxt;
      s5_sens2_r <= s5_sens2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: final OFF and SENS
  // ---------------------------------------------------------------------------
  logic [bcomp_pkg::RAW_W-1:0] s6_d1_r;
  logic signed [19:0]          s6_temp_r;
  logic signed [39:0]          s6_off_r, s6_off_nxt;
  logic signed [39:0]          s6_sens_r, s6_sens_nxt;
  logic signed [39:0]          off1_ext, sens1_ext;

  always_comb begin
    off1_ext    = s5_off1_r;
    sens1_ext   = s5_sens1_r;
    s6_off_nxt  = off1_ext - $signed({1'b0, s5_off2_r});
    s6_sens_nxt = sens1_ext - $signed({1'b0, s5_sens2_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_d1_r   <= s5_d1_r;
      s6_temp_r <= s5_temp_r;
      s6_off_r  <= s6_off_nxt;
      s6_sens_r <= s6_sens_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: D1 * SENS as two partial products (low 20 bits and signed high)
  // ---------------------------------------------------------------------------
  logic signed [19:0] s7_temp_r;
  logic signed [39:0] s7_off_r;
  logic [43:0]        s7_pp_lo_r, s7_pp_lo_nxt;
  logic signed [44:0] s7_pp_hi_r, s7_pp_hi_nxt;

  always_comb begin
    s7_pp_lo_nxt = s6_d1_r * s6_sens_r[19:0];
    s7_pp_hi_nxt = $signed({1'b0, s6_d1_r}) * $signed(s6_sens_r[39:20]);
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_temp_r  <= s6_temp_r;
      s7_off_r   <= s6_off_r;
      s7_pp_lo_r <= s7_pp_lo_nxt;
      s7_pp_hi_r <= s7_pp_hi_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: recombine the partial products
  // ---------------------------------------------------------------------------
  logic signed [19:0] s8_temp_r;
  logic signed [39:0] s8_off_r;
  logic signed [63:0] s8_prod_r, s8_prod_nxt;
  logic signed [63:0] pp_hi_ext;

  always_comb begin
    pp_hi_ext   = s7_pp_hi_r;
    s8_prod_nxt = (pp_hi_ext <<< 20) + $signed({20'h00000, s7_pp_lo_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s8_temp_r <= s7_temp_r;
      s8_off_r  <= s7_off_r;
      s8_prod_r <= s8_prod_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9 (output register): P = (D1*SENS/2^21 - OFF)/2^15
  // ---------------------------------------------------------------------------
  bcomp_pkg::out_t    out_r, out_nxt;
  logic signed [43:0] p_diff;
  logic signed [43:0] off_ext;

  always_comb begin
    off_ext                 = s8_off_r;
    p_diff                  = $signed(s8_prod_r[63:21]) - off_ext;
    out_nxt.pressure_out    = $signed(p_diff[43:15]);
    out_nxt.temperature_out = s8_temp_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Backpressure only reaches the input once every stage is full.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("in_ready low with an empty pipeline stage");

  // An input transfer always lands in the first stage.
  a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted item missing from first stage");

  // A stalled mid-pipeline item is never dropped.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] && !rdy[5] |=> v_r[4])
    else $error("stalled item lost in correction stage");

  // An empty output register never blocks the pipeline.
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> rdy[8] && (rdy[7] || !v_r[7]))
    else $error("output stage empty but pipeline stalled");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for barometer_compensation: directed table, then random readings.
// Depends on bcomp_pkg and the barometer_compensation RTL; needs nothing else.
module tb_top;

  localparam int RAW_MAX         = 16777215;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 244;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PRINT_CAP       = 40;

  // Indexes past the last calibration word; the block must drop writes to them
  localparam logic [bcomp_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [bcomp_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;
  typedef enum int { CAL_ANY, CAL_RAILS, CAL_TYPICAL } cal_mode_t;
  typedef enum int { BAND_WARM, BAND_COOL, BAND_COLD } temp_band_t;

  // One directed step: a register write, or a reading with an optional typed-in result
  typedef struct packed {
    row_kind_t                          kind;
    logic [bcomp_pkg::CFG_IDX_W-1:0]    idx;
    logic [bcomp_pkg::CAL_W-1:0]        val;
    logic [bcomp_pkg::RAW_W-1:0]        d1;
    logic [bcomp_pkg::RAW_W-1:0]        d2;
    logic                               typed;
    logic signed [bcomp_pkg::OUT_W-1:0] want_p;
    logic signed [bcomp_pkg::OUT_W-1:0] want_t;
  } stim_row_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  bcomp_pkg::in_t                  in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  bcomp_pkg::out_t                 out_data;
  logic                            cfg_we    = 1'b0;
  logic [bcomp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bcomp_pkg::CAL_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the calibration words, updated on each write to a calibration word
  logic [bcomp_pkg::CAL_W-1:0] cal_q [bcomp_pkg::CAL_WORDS] = '{default: '0};
  bcomp_pkg::out_t due_q [$];

  bit no_idle    = 1'b0;
  int hold_cnt   = 0;
  int cycle_cnt  = 0;
  int n_errors   = 0;
  int n_sent     = 0;
  int n_results  = 0;
  int n_settings = 1;
  int n_cool     = 0;
  int n_cold     = 0;

  // Zero calibration gives TEMP = 2000 and P = 0 whatever the readings are.
  stim_row_t directed [$] = '{
    '{ROW_ITEM,  '0, '0, 24'h000000, 24'h000000, 1'b1, 32'sd0, 32'sd2000},
    '{ROW_ITEM,  '0, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'sd0, 32'sd2000},
    '{ROW_ITEM,  '0, '0, 24'hFFFFFF, 24'h000000, 1'b1, 32'sd0, 32'sd2000},
    '{ROW_ITEM,  '0, '0, 24'h000000, 24'hFFFFFF, 1'b1, 32'sd0, 32'sd2000},
    '{ROW_WRITE, REG_SPARE_6, 16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_SPARE_7, 16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'hAAAAAA, 24'h555555, 1'b1, 32'sd0, 32'sd2000},
    // Typical factory calibration
    '{ROW_WRITE, bcomp_pkg::REG_PRESSURE_SENS, 16'd40127, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_PRESSURE_OFF,  16'd36924, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_SENS_TCO,      16'd23317, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_OFF_TCO,       16'd23282, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_REF_TEMP,      16'd33464, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_TEMP_TCO,      16'd28312, '0, '0, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'd9085466, 24'd8569150, 1'b0, '0, '0},
    // dT = 0 sits right on 20.00 C; one count lower takes the second-order path
    '{ROW_ITEM,  '0, '0, 24'd9085466, 24'd8566784, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'd9085466, 24'd8566783, 1'b0, '0, '0},
    // First-order TEMP of exactly -15.00 C, then one count colder
    '{ROW_ITEM,  '0, '0, 24'd9085466, 24'd7529764, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'd9085466, 24'd7529763, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'hFFFFFF, 24'd7529762, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'h000000, 24'h000000, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0},
    // Every word at full scale
    '{ROW_WRITE, bcomp_pkg::REG_PRESSURE_SENS, 16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_PRESSURE_OFF,  16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_SENS_TCO,      16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_OFF_TCO,       16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_REF_TEMP,      16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, bcomp_pkg::REG_TEMP_TCO,      16'hFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'h000000, 24'h000000, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'hFFFFFF, 24'h000000, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'h000000, 24'hFFFFFF, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 24'h555555, 24'hAAAAAA, 1'b0, '0, '0}
  };

  barometer_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Mostly back-to-back, some short gaps, a rare long one
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Compensated pressure and temperature for one reading under the shadow calibration.
  // All terms are 64-bit signed; >>> floors, as the sensor math expects.
  function automatic bcomp_pkg::out_t predict_reading(input bcomp_pkg::in_t rd,
                                                      output temp_band_t band);
    longint          d1, d2, sens_w, off_w, tcs_w, tco_w, tref_w, tts_w;
    longint          dt, t1, tc, off, sens, lo, vlo, t2, off2, sens2, p;
    bcomp_pkg::out_t res;
    d1     = rd.raw_pressure;
    d2     = rd.raw_temperature;
    sens_w = cal_q[bcomp_pkg::REG_PRESSURE_SENS];
    off_w  = cal_q[bcomp_pkg::REG_PRESSURE_OFF];
    tcs_w  = cal_q[bcomp_pkg::REG_SENS_TCO];
    tco_w  = cal_q[bcomp_pkg::REG_OFF_TCO];
    tref_w = cal_q[bcomp_pkg::REG_REF_TEMP];
    tts_w  = cal_q[bcomp_pkg::REG_TEMP_TCO];
    band   = BAND_WARM;

    dt   = d2 - tref_w * 256;
    t1   = bcomp_pkg::TEMP_REF + ((dt * tts_w) >>> 23);
    off  = off_w * 65536 + ((tco_w * dt) >>> 7);
    sens = sens_w * 32768 + ((tcs_w * dt) >>> 8);
    tc   = t1;
    // Threshold tests use the first-order temperature
    if (t1 < bcomp_pkg::TEMP_REF) begin
      band  = BAND_COOL;
      lo    = t1 - bcomp_pkg::TEMP_REF;
      t2    = (dt * dt) >>> 31;
      off2  = (5 * lo * lo) >>> 1;
      sens2 = (5 * lo * lo) >>> 2;
      if (t1 < bcomp_pkg::TEMP_COLD) begin
        band  = BAND_COLD;
        vlo   = t1 - bcomp_pkg::TEMP_COLD;
        off2  = off2 + 7 * vlo * vlo;
        sens2 = sens2 + ((11 * vlo * vlo) >>> 1);
      end
      tc   = t1 - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;

    // Keep the low 32 bits only, no saturation
    res.pressure_out    = p[bcomp_pkg::OUT_W-1:0];
    res.temperature_out = tc[bcomp_pkg::OUT_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (n_errors < PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    n_errors++;
  endtask

  // Drive one write; the caller drops cfg_we after the last one of a batch
  task automatic write_reg(input logic [bcomp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bcomp_pkg::CAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < bcomp_pkg::CAL_WORDS) cal_q[idx] = val;
  endtask

  // Offer one reading and wait for its transfer. in_valid stays high after the
  // transfer so that a zero gap keeps the channel busy; a gap lowers it first.
  task automatic push_reading(input bcomp_pkg::in_t item, input logic typed,
                              input bcomp_pkg::out_t want);
    int              gap;
    temp_band_t      band;
    bcomp_pkg::out_t calc;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    calc = predict_reading(item, band);
    due_q.push_back(typed ? want : calc);
    n_sent++;
    if (band != BAND_WARM) n_cool++;
    if (band == BAND_COLD) n_cold++;
  endtask

  // Drop valid, wait for every result, then let the pipeline run empty
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (bcomp_pkg::NUM_STAGES + 2) @(posedge clk);
  endtask

  // Result side back-pressure: runs of ready, broken by stalls of random length
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (no_idle || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      hold_cnt  <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b0;
      hold_cnt  <= idle_len();
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    bcomp_pkg::out_t want;
    if (rst_n && $isunknown(out_valid)) flag_mismatch("out_valid is unknown");
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (due_q.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = due_q.pop_front();
        if (out_data.pressure_out !== want.pressure_out)
          flag_mismatch($sformatf("result %0d pressure_out got %0d want %0d", n_results,
                                  out_data.pressure_out, want.pressure_out));
        if (out_data.temperature_out !== want.temperature_out)
          flag_mismatch($sformatf("result %0d temperature_out got %0d want %0d", n_results,
                                  out_data.temperature_out, want.temperature_out));
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_cnt, due_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    bcomp_pkg::in_t              item;
    bcomp_pkg::out_t             want;
    cal_mode_t                   mode;
    logic [bcomp_pkg::CAL_W-1:0] word;
    logic                        in_cfg;
    int                          r, base, span, v;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: writes are batched and only issued on an empty pipeline
    in_cfg = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        if (!in_cfg) begin
          settle_pipeline();
          in_cfg = 1'b1;
        end
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        if (in_cfg) begin
          cfg_we <= 1'b0;
          in_cfg = 1'b0;
          n_settings++;
        end
        item.raw_pressure    = directed[i].d1;
        item.raw_temperature = directed[i].d2;
        want.pressure_out    = directed[i].want_p;
        want.temperature_out = directed[i].want_t;
        push_reading(item, directed[i].typed, want);
      end
    end

    // Random phases: fresh calibration each time, then a run of readings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_pipeline();
      mode = cal_mode_t'(ph % 3);
      for (int k = 0; k < bcomp_pkg::CAL_WORDS; k++) begin
        case (mode)
          CAL_RAILS:   word = $urandom_range(0, 1) ? '1 : '0;
          CAL_TYPICAL: word = 16'($urandom_range(16'h6000, 16'hBFFF));
          default:     word = 16'($urandom_range(0, 16'hFFFF));
        endcase
        write_reg(bcomp_pkg::cal_reg_t'(k), word);
      end
      // Poke a spare index now and then; the shadow must stay unchanged
      if ($urandom_range(0, 1) != 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                  16'($urandom_range(0, 16'hFFFF)));
      cfg_we <= 1'b0;
      n_settings++;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 64 == 0) no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) item.raw_pressure = $urandom_range(0, 1) ? '1 : '0;
        else item.raw_pressure = 24'($urandom_range(0, RAW_MAX));

        // Aim D2 near the reference point often, so both correction bands are hit
        r    = $urandom_range(0, 9);
        base = int'(cal_q[bcomp_pkg::REG_REF_TEMP]) * 256;
        if (r < 4) begin
          v = $urandom_range(0, RAW_MAX);
        end else if (r < 9) begin
          span = 1 << $urandom_range(0, 23);
          v = $urandom_range(0, 1) ? base + int'($urandom_range(0, span))
                                   : base - int'($urandom_range(0, span));
        end else begin
          case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = RAW_MAX;
            2:       v = base;
            default: v = base - 1;
          endcase
        end
        if (v < 0) v = 0;
        else if (v > RAW_MAX) v = RAW_MAX;
        item.raw_temperature = v[bcomp_pkg::RAW_W-1:0];
        push_reading(item, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    settle_pipeline();

    $display("Checked %0d results from %0d readings under %0d calibration settings",
             n_results, n_sent, n_settings);
    $display("%0d readings took the below-20.00 C path, %0d also the below-15.00 C term",
             n_cool, n_cold);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
